FILE: hdl/qrcb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrcb_pkg
// Shared widths, types and register codes for the quartic root count bound.
// ---------------------------------------------------------------------------
package qrcb_pkg;

   // Coefficients are signed Q16.16, points are signed Q8.8.
   localparam int COEF_WIDTH  = 32;
   localparam int POINT_WIDTH = 16;
   localparam int POINT_FRAC  = POINT_WIDTH / 2;

   // Largest scaled term is five monomials of |coef| * |p|^4, plus a sign bit.
   localparam int TERM_W  = COEF_WIDTH + 4 * POINT_WIDTH - 1;
   // Multiplier operand holds p, 4p or 6p.
   localparam int MUL_W   = POINT_WIDTH + 3;

   // Wide operand is split into slices for the multiply-add.
   localparam int CHUNK_W = 32;
   localparam int NCHUNK  = (TERM_W + CHUNK_W - 1) / CHUNK_W;
   localparam int XW      = NCHUNK * CHUNK_W;
   localparam int PROD_W  = CHUNK_W + 1 + MUL_W;
   localparam int ACC_W   = XW + MUL_W + 1;

   localparam int MAC_LAT    = 2;
   localparam int LEVELS     = 4;
   localparam int NTERMS     = 5;
   localparam int PNT_STAGES = (LEVELS - 1) * MAC_LAT + 1;
   localparam int SG1_N      = (LEVELS - 1) * MAC_LAT;
   localparam int SG2_N      = (LEVELS - 2) * MAC_LAT;
   localparam int SG3_N      = (LEVELS - 3) * MAC_LAT;
   localparam int LANE_DEPTH = LEVELS * MAC_LAT + 2;

   localparam int CNT_W       = 3;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUARTIC,
      CSR_CUBIC,
      CSR_SQUARE,
      CSR_LINEAR,
      CSR_CONSTANT
   } csr_index_type;

   // Coefficients pre-scaled by the matching power of 2^POINT_FRAC.
   typedef struct packed {
      logic signed [TERM_W-1:0] a_op;
      logic signed [TERM_W-1:0] b_op;
      logic signed [TERM_W-1:0] b3_op;
      logic signed [TERM_W-1:0] c_op;
      logic signed [TERM_W-1:0] c2_op;
      logic signed [TERM_W-1:0] d_op;
      logic signed [TERM_W-1:0] e_op;
   } coef_ops_type;

   typedef struct packed {
      logic nz;
      logic neg;
   } sign_type;

endpackage

FILE: hdl/qrcb_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrcb_cfg
// Coefficient registers, presented as scaled wide operands to the lanes.
// ---------------------------------------------------------------------------
module qrcb_cfg (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [qrcb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic signed [qrcb_pkg::COEF_WIDTH-1:0]  csr_data,
   output qrcb_pkg::coef_ops_type                  cfg_coef
);
   import qrcb_pkg::*;

   logic signed [COEF_WIDTH-1:0] quartic_ff;
   logic signed [COEF_WIDTH-1:0] cubic_ff;
   logic signed [COEF_WIDTH+1:0] cubic3_ff;
   logic signed [COEF_WIDTH+1:0] cubic3_in;
   logic signed [COEF_WIDTH-1:0] square_ff;
   logic signed [COEF_WIDTH-1:0] linear_ff;
   logic signed [COEF_WIDTH-1:0] const_ff;

   assign csr_ready = 1'b1;

   // 3b is formed on the write so the lanes only see shifts
   assign cubic3_in = (COEF_WIDTH+2)'(csr_data) + ((COEF_WIDTH+2)'(csr_data) <<< 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         quartic_ff <= '0;
         cubic_ff   <= '0;
         cubic3_ff  <= '0;
         square_ff  <= '0;
         linear_ff  <= '0;
         const_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_QUARTIC: begin
               quartic_ff <= csr_data;
            end
            CSR_CUBIC: begin
               cubic_ff  <= csr_data;
               cubic3_ff <= cubic3_in;
            end
            CSR_SQUARE: begin
               square_ff <= csr_data;
            end
            CSR_LINEAR: begin
               linear_ff <= csr_data;
            end
            CSR_CONSTANT: begin
               const_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg_coef.a_op  = TERM_W'(quartic_ff);
      cfg_coef.b_op  = TERM_W'(cubic_ff) <<< POINT_FRAC;
      cfg_coef.b3_op = TERM_W'(cubic3_ff) <<< POINT_FRAC;
      cfg_coef.c_op  = TERM_W'(square_ff) <<< (2 * POINT_FRAC);
      cfg_coef.c2_op = TERM_W'(square_ff) <<< (2 * POINT_FRAC + 1);
      cfg_coef.d_op  = TERM_W'(linear_ff) <<< (3 * POINT_FRAC);
      cfg_coef.e_op  = TERM_W'(const_ff) <<< (4 * POINT_FRAC);
   end

endmodule

FILE: hdl/qrcb_mac.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrcb_mac
// Two-stage y = x * m + z on wide signed x, with x cut into 32-bit slices.
// ---------------------------------------------------------------------------
module qrcb_mac (
   input  logic                                clock,
   input  logic                                mac_en,
   input  logic signed [qrcb_pkg::TERM_W-1:0]  mac_x,
   input  logic signed [qrcb_pkg::MUL_W-1:0]   mac_m,
   input  logic signed [qrcb_pkg::TERM_W-1:0]  mac_z,
   output logic signed [qrcb_pkg::TERM_W-1:0]  mac_y
);
   import qrcb_pkg::*;

   logic signed [XW-1:0]     x_ext;
   logic signed [PROD_W-1:0] prod_in [NCHUNK];
   logic signed [PROD_W-1:0] prod_ff [NCHUNK];
   logic signed [TERM_W-1:0] addend_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [TERM_W-1:0] y_ff;

   assign x_ext = XW'(mac_x);

   // low slices are unsigned, the top slice carries the sign
   always_comb begin
      logic signed [CHUNK_W:0] part;
      part = '0;
      for (int i = 0; i < NCHUNK; i++) begin
         if (i == NCHUNK - 1) begin
            part = {x_ext[XW-1], x_ext[i*CHUNK_W +: CHUNK_W]};
         end else begin
            part = {1'b0, x_ext[i*CHUNK_W +: CHUNK_W]};
         end
         prod_in[i] = part * mac_m;
      end
   end

   always_comb begin
      acc_in = ACC_W'(addend_ff);
      for (int i = 0; i < NCHUNK; i++) begin
         acc_in = acc_in + (ACC_W'(prod_ff[i]) <<< (i * CHUNK_W));
      end
   end

   always_ff @(posedge clock) begin
      if (mac_en) begin
         prod_ff   <= prod_in;
         addend_ff <= mac_z;
         y_ff      <= acc_in[TERM_W-1:0];
      end
   end

   assign mac_y = y_ff;

endmodule

FILE: hdl/qrcb_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrcb_lane
// Evaluates the scaled derivative sequence at one point and counts its
// strict sign changes.
// ---------------------------------------------------------------------------
module qrcb_lane (
   input  logic                                 clock,
   input  logic                                 lane_en,
   input  qrcb_pkg::coef_ops_type               lane_coef,
   input  logic signed [qrcb_pkg::POINT_WIDTH-1:0] lane_point,
   output logic        [qrcb_pkg::CNT_W-1:0]    lane_changes
);
   import qrcb_pkg::*;

   logic signed [POINT_WIDTH-1:0] point_pipe_ff [PNT_STAGES];
   logic signed [MUL_W-1:0]       mul4_in;
   logic signed [MUL_W-1:0]       mul6_in;
   logic signed [MUL_W-1:0]       mul4_ff;
   logic signed [MUL_W-1:0]       mul6_ff;

   logic signed [TERM_W-1:0] t4_y [LEVELS];
   logic signed [TERM_W-1:0] t3_y [LEVELS-1];
   logic signed [TERM_W-1:0] t2_y [LEVELS-2];
   logic signed [TERM_W-1:0] t1_y;

   sign_type             sg1_ff [SG1_N];
   sign_type             sg2_ff [SG2_N];
   sign_type             sg3_ff [SG3_N];
   sign_type             seq    [NTERMS];
   logic [CNT_W-1:0]     changes_in;
   logic [CNT_W-1:0]     changes_ff;

   function automatic sign_type term_sign(input logic signed [TERM_W-1:0] t);
      sign_type s;
      s.nz  = |t;
      s.neg = t[TERM_W-1];
      return s;
   endfunction

   assign mul4_in = MUL_W'(lane_point) <<< 2;
   assign mul6_in = mul4_in + (MUL_W'(lane_point) <<< 1);

   // Each term is its own Horner chain in p:
   //   f      = (((a p + B) p + C) p + D) p + E
   //   f'     = ((4a p + 3B) p + 2C) p + D
   //   f''/2  = (6a p + 3B) p + C
   //   f'''/6 = 4a p + B
   qrcb_mac u_t4_l1 (.clock(clock), .mac_en(lane_en), .mac_x(lane_coef.a_op),
      .mac_m(MUL_W'(point_pipe_ff[0])), .mac_z(lane_coef.b_op), .mac_y(t4_y[0]));
   qrcb_mac u_t4_l2 (.clock(clock), .mac_en(lane_en), .mac_x(t4_y[0]),
      .mac_m(MUL_W'(point_pipe_ff[MAC_LAT])), .mac_z(lane_coef.c_op), .mac_y(t4_y[1]));
   qrcb_mac u_t4_l3 (.clock(clock), .mac_en(lane_en), .mac_x(t4_y[1]),
      .mac_m(MUL_W'(point_pipe_ff[2*MAC_LAT])), .mac_z(lane_coef.d_op), .mac_y(t4_y[2]));
   qrcb_mac u_t4_l4 (.clock(clock), .mac_en(lane_en), .mac_x(t4_y[2]),
      .mac_m(MUL_W'(point_pipe_ff[3*MAC_LAT])), .mac_z(lane_coef.e_op), .mac_y(t4_y[3]));

   qrcb_mac u_t3_l1 (.clock(clock), .mac_en(lane_en), .mac_x(lane_coef.a_op),
      .mac_m(mul4_ff), .mac_z(lane_coef.b3_op), .mac_y(t3_y[0]));
   qrcb_mac u_t3_l2 (.clock(clock), .mac_en(lane_en), .mac_x(t3_y[0]),
      .mac_m(MUL_W'(point_pipe_ff[MAC_LAT])), .mac_z(lane_coef.c2_op), .mac_y(t3_y[1]));
   qrcb_mac u_t3_l3 (.clock(clock), .mac_en(lane_en), .mac_x(t3_y[1]),
      .mac_m(MUL_W'(point_pipe_ff[2*MAC_LAT])), .mac_z(lane_coef.d_op), .mac_y(t3_y[2]));

   qrcb_mac u_t2_l1 (.clock(clock), .mac_en(lane_en), .mac_x(lane_coef.a_op),
      .mac_m(mul6_ff), .mac_z(lane_coef.b3_op), .mac_y(t2_y[0]));
   qrcb_mac u_t2_l2 (.clock(clock), .mac_en(lane_en), .mac_x(t2_y[0]),
      .mac_m(MUL_W'(point_pipe_ff[MAC_LAT])), .mac_z(lane_coef.c_op), .mac_y(t2_y[1]));

   qrcb_mac u_t1_l1 (.clock(clock), .mac_en(lane_en), .mac_x(lane_coef.a_op),
      .mac_m(mul4_ff), .mac_z(lane_coef.b_op), .mac_y(t1_y));

   // early terms finish first; only their signs travel on to the count
   always_ff @(posedge clock) begin
      if (lane_en) begin
         point_pipe_ff[0] <= lane_point;
         for (int k = 1; k < PNT_STAGES; k++) begin
            point_pipe_ff[k] <= point_pipe_ff[k-1];
         end
         mul4_ff <= mul4_in;
         mul6_ff <= mul6_in;

         sg1_ff[0] <= term_sign(t1_y);
         for (int k = 1; k < SG1_N; k++) begin
            sg1_ff[k] <= sg1_ff[k-1];
         end
         sg2_ff[0] <= term_sign(t2_y[LEVELS-3]);
         for (int k = 1; k < SG2_N; k++) begin
            sg2_ff[k] <= sg2_ff[k-1];
         end
         sg3_ff[0] <= term_sign(t3_y[LEVELS-2]);
         for (int k = 1; k < SG3_N; k++) begin
            sg3_ff[k] <= sg3_ff[k-1];
         end

         changes_ff <= changes_in;
      end
   end

   // a zero term breaks both pairs it belongs to
   always_comb begin
      seq[0] = term_sign(lane_coef.a_op);
      seq[1] = sg1_ff[SG1_N-1];
      seq[2] = sg2_ff[SG2_N-1];
      seq[3] = sg3_ff[SG3_N-1];
      seq[4] = term_sign(t4_y[LEVELS-1]);
      changes_in = '0;
      for (int i = 0; i < NTERMS - 1; i++) begin
         changes_in = changes_in
            + CNT_W'(seq[i].nz & seq[i+1].nz & (seq[i].neg ^ seq[i+1].neg));
      end
   end

   assign lane_changes = changes_ff;

endmodule

FILE: hdl/quartic_root_count_bound_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quartic_root_count_bound_core
// Budan-Fourier bound on the real roots of a quartic between two points.
// The five coefficients (signed Q16.16) are written through the csr_ port,
// index 0 for x^4 down to 4 for the constant; other indexes are ignored.
// Each request carries a left and a right point (signed Q8.8). Two lanes
// evaluate a, 4ax+b, 6ax^2+3bx+c, f'(x) and f(x) exactly at the two points,
// count strict sign changes (a zero term breaks its pairs), and a merge stage
// returns both counts and their absolute difference. The core takes one
// request per clock unless a finished result is stalled at the output. A
// response passes through the point register, which loads on the accept
// edge, then four chained Horner levels, each a two-stage multiply-add over
// a wide operand in 32-bit slices, then the count stage and the output
// register. Coefficients must only change while no request is in flight.
// ---------------------------------------------------------------------------
module quartic_root_count_bound_core (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [qrcb_pkg::POINT_WIDTH-1:0] req_left_point,
   input  logic signed [qrcb_pkg::POINT_WIDTH-1:0] req_right_point,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic        [qrcb_pkg::CNT_W-1:0]       rsp_root_bound,
   output logic        [qrcb_pkg::CNT_W-1:0]       rsp_left_changes,
   output logic        [qrcb_pkg::CNT_W-1:0]       rsp_right_changes,

   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [qrcb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic signed [qrcb_pkg::COEF_WIDTH-1:0]  csr_data
);
   import qrcb_pkg::*;

   coef_ops_type          coef;
   logic                  adv;
   logic                  load_out;
   logic [LANE_DEPTH-1:0] pipe_vld_ff;
   logic [CNT_W-1:0]      left_cnt;
   logic [CNT_W-1:0]      right_cnt;
   logic [CNT_W-1:0]      bound_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CNT_W-1:0]      rsp_root_bound_ff;
   logic [CNT_W-1:0]      rsp_left_changes_ff;
   logic [CNT_W-1:0]      rsp_right_changes_ff;

   qrcb_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg_coef  (coef)
   );

   qrcb_lane u_lane_left (
      .clock        (clock),
      .lane_en      (adv),
      .lane_coef    (coef),
      .lane_point   (req_left_point),
      .lane_changes (left_cnt)
   );

   qrcb_lane u_lane_right (
      .clock        (clock),
      .lane_en      (adv),
      .lane_coef    (coef),
      .lane_point   (req_right_point),
      .lane_changes (right_cnt)
   );

   // pipeline only holds when a finished result has nowhere to go
   assign adv       = !pipe_vld_ff[LANE_DEPTH-1] || !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign load_out  = pipe_vld_ff[LANE_DEPTH-1] && adv;

   assign bound_in = (left_cnt >= right_cnt) ? (left_cnt - right_cnt)
                                             : (right_cnt - left_cnt);

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            pipe_vld_ff <= {pipe_vld_ff[LANE_DEPTH-2:0], req_valid};
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_root_bound_ff    <= bound_in;
         rsp_left_changes_ff  <= left_cnt;
         rsp_right_changes_ff <= right_cnt;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_root_bound    = rsp_root_bound_ff;
   assign rsp_left_changes  = rsp_left_changes_ff;
   assign rsp_right_changes = rsp_right_changes_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (pipe_vld_ff[LANE_DEPTH-1] && rsp_valid_ff && !rsp_ready) |=> $stable(pipe_vld_ff))
      else $error("pipeline advanced while the output register was stalled");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (pipe_vld_ff[LANE_DEPTH-1] && adv) |=> rsp_valid_ff)
      else $error("finished request did not reach the output register");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> pipe_vld_ff[0])
      else $error("accepted request missing from the first stage");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_left_changes_ff <= CNT_W'(NTERMS - 1)
                     && rsp_right_changes_ff <= CNT_W'(NTERMS - 1)
                     && rsp_root_bound_ff <= CNT_W'(NTERMS - 1)))
      else $error("sign change count out of range");

endmodule

FILE: tb/sv/tb_quartic_root_count_bound_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_quartic_root_count_bound_core
// Self-checking bench for the Budan-Fourier root count bound core. A short
// directed table (all-zero and known-root polynomials, point extremes,
// reversed intervals, points on roots) is followed by random phases. Each
// phase loads a new coefficient set through the csr_ port: all extremes,
// polynomials built from chosen roots, full-range and sparse sets. Results
// are checked in order against an exact wide-integer model of the sign
// change counts. The request side is driven in bursts with gaps, and the
// response side stalls on a pattern that switches over time.
// ---------------------------------------------------------------------------
module tb_quartic_root_count_bound_core;

   import qrcb_pkg::*;

   localparam int NUM_COEFS       = int'(CSR_CONSTANT) + 1;
   localparam int SEQ_LEN         = 5;
   localparam int WIDE_W          = 192;
   localparam int NUM_PHASES      = 12;
   localparam int ITEMS_PER_PHASE = 92;
   localparam int PRESSURE_PHASE  = 5;
   localparam int TAIL_CYCLES     = 30;
   localparam int DIRECTED_ROWS   = 18;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_INDEX_W'(NUM_COEFS);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = '1;

   localparam logic signed [COEF_WIDTH-1:0]  ONE_Q16   = 32'sh0001_0000;
   localparam logic signed [COEF_WIDTH-1:0]  COEF_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [COEF_WIDTH-1:0]  COEF_MIN  = 32'sh8000_0000;
   localparam logic signed [POINT_WIDTH-1:0] POINT_MAX = 16'sh7FFF;
   localparam logic signed [POINT_WIDTH-1:0] POINT_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_PAIR,
      ROW_PAIR_KNOWN
   } row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [CSR_INDEX_W-1:0]         index;
      logic signed [COEF_WIDTH-1:0]   data;
      logic signed [POINT_WIDTH-1:0]  left_pt;
      logic signed [POINT_WIDTH-1:0]  right_pt;
      logic [CNT_W-1:0]               want_bound;
      logic [CNT_W-1:0]               want_left;
      logic [CNT_W-1:0]               want_right;
   } stim_row_type;

   typedef struct packed {
      logic [CNT_W-1:0] bound;
      logic [CNT_W-1:0] left_cnt;
      logic [CNT_W-1:0] right_cnt;
   } root_count_type;

   typedef enum {
      COEFS_ALL_MAX,
      COEFS_ALL_MIN,
      COEFS_EXTREME_MIX,
      COEFS_ROOTS,
      COEFS_WIDE,
      COEFS_SPARSE
   } coef_set_type;

   typedef enum {
      RSP_ALWAYS,
      RSP_MOSTLY,
      RSP_SELDOM,
      RSP_PERIODIC
   } rsp_mode_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic signed [POINT_WIDTH-1:0]  req_left_point;
   logic signed [POINT_WIDTH-1:0]  req_right_point;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [CNT_W-1:0]               rsp_root_bound;
   logic [CNT_W-1:0]               rsp_left_changes;
   logic [CNT_W-1:0]               rsp_right_changes;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [CSR_INDEX_W-1:0]         csr_index;
   logic signed [COEF_WIDTH-1:0]   csr_data;

   logic signed [COEF_WIDTH-1:0]   coef_model [NUM_COEFS];
   logic signed [COEF_WIDTH-1:0]   next_coef [NUM_COEFS];
   int                             root_k [4];
   bit                             root_phase;
   root_count_type                 pending_counts [$];
   int                             mismatches;
   rsp_mode_type                   rsp_mode;
   int                             rsp_mode_left;
   int unsigned                    rsp_tick;

   // x^4 - 5x^2 + 4 has roots at -2, -1, 1 and 2
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_CSR,        CSR_SPARE_FIRST, COEF_MAX,    0,         0,         0, 0, 0},
      '{ROW_PAIR_KNOWN, CSR_QUARTIC,     0,           POINT_MIN, POINT_MAX, 0, 0, 0},
      '{ROW_PAIR_KNOWN, CSR_QUARTIC,     0,           POINT_MAX, POINT_MIN, 0, 0, 0},
      '{ROW_PAIR_KNOWN, CSR_QUARTIC,     0,           0,         0,         0, 0, 0},
      '{ROW_PAIR_KNOWN, CSR_QUARTIC,     0,           -1,        1,         0, 0, 0},
      '{ROW_CSR,        CSR_QUARTIC,     ONE_Q16,     0,         0,         0, 0, 0},
      '{ROW_CSR,        CSR_CUBIC,       0,           0,         0,         0, 0, 0},
      '{ROW_CSR,        CSR_SQUARE,      -5 * ONE_Q16, 0,        0,         0, 0, 0},
      '{ROW_CSR,        CSR_LINEAR,      0,           0,         0,         0, 0, 0},
      '{ROW_CSR,        CSR_CONSTANT,    4 * ONE_Q16, 0,         0,         0, 0, 0},
      '{ROW_PAIR,       CSR_QUARTIC,     0,           -768,      768,       0, 0, 0},
      '{ROW_PAIR,       CSR_QUARTIC,     0,           768,       -768,      0, 0, 0},
      '{ROW_PAIR,       CSR_QUARTIC,     0,           0,         0,         0, 0, 0},
      '{ROW_PAIR,       CSR_QUARTIC,     0,           256,       512,       0, 0, 0},
      '{ROW_PAIR,       CSR_QUARTIC,     0,           -512,      -256,      0, 0, 0},
      '{ROW_PAIR,       CSR_QUARTIC,     0,           POINT_MIN, POINT_MAX, 0, 0, 0},
      '{ROW_PAIR,       CSR_QUARTIC,     0,           POINT_MAX, POINT_MIN, 0, 0, 0},
      '{ROW_PAIR,       CSR_QUARTIC,     0,           -1,        1,         0, 0, 0}
   };

   quartic_root_count_bound_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_point    (req_left_point),
      .req_right_point   (req_right_point),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_root_bound    (rsp_root_bound),
      .rsp_left_changes  (rsp_left_changes),
      .rsp_right_changes (rsp_right_changes),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Sign changes of the derivative sequence, every term scaled by the
   // power of 2^POINT_FRAC that makes it an integer.
   function automatic int unsigned changes_at_point(input logic signed [POINT_WIDTH-1:0] pt);
      logic signed [WIDE_W-1:0] a, b, c, d, e, p, s;
      logic signed [WIDE_W-1:0] term [SEQ_LEN];
      int                       sgn [SEQ_LEN];
      int unsigned              n;
      a = coef_model[CSR_QUARTIC];
      b = coef_model[CSR_CUBIC];
      c = coef_model[CSR_SQUARE];
      d = coef_model[CSR_LINEAR];
      e = coef_model[CSR_CONSTANT];
      p = pt;
      s = 1 <<< POINT_FRAC;
      term[0] = a;
      term[1] = 4 * a * p + b * s;
      term[2] = 6 * a * p * p + 3 * b * p * s + c * s * s;
      term[3] = 4 * a * p * p * p + 3 * b * p * p * s + 2 * c * p * s * s + d * s * s * s;
      term[4] = a * p * p * p * p + b * p * p * p * s + c * p * p * s * s
                + d * p * s * s * s + e * s * s * s * s;
      n = 0;
      for (int i = 0; i < SEQ_LEN; i++)
         sgn[i] = (term[i] < 0) ? -1 : ((term[i] != 0) ? 1 : 0);
      // a zero term breaks both of its pairs
      for (int i = 0; i < SEQ_LEN - 1; i++)
         if (sgn[i] * sgn[i + 1] < 0)
            n++;
      return n;
   endfunction

   function automatic root_count_type predict_counts(input logic signed [POINT_WIDTH-1:0] lp,
                                                     input logic signed [POINT_WIDTH-1:0] rp);
      root_count_type rc;
      int unsigned vl, vr;
      vl = changes_at_point(lp);
      vr = changes_at_point(rp);
      rc.left_cnt  = CNT_W'(vl);
      rc.right_cnt = CNT_W'(vr);
      rc.bound     = CNT_W'((vl >= vr) ? vl - vr : vr - vl);
      return rc;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR @%0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // All driving tasks start and end at a falling edge.
   task automatic write_coef(input logic [CSR_INDEX_W-1:0] idx,
                             input logic signed [COEF_WIDTH-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_COEFS)
         coef_model[idx] = val;
      @(negedge clock);
   endtask

   task automatic send_pair(input logic signed [POINT_WIDTH-1:0] lp,
                            input logic signed [POINT_WIDTH-1:0] rp,
                            input root_count_type want);
      req_left_point  <= lp;
      req_right_point <= rp;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_counts.push_back(want);
      @(negedge clock);
   endtask

   task automatic pause_requests(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_counts.size() != 0)
         @(negedge clock);
   endtask

   // Monic-times-scale polynomial with roots k/16, exact in Q16.16.
   task automatic make_root_coefs();
      int s1, s2, s3, s4, m;
      for (int i = 0; i < 4; i++)
         root_k[i] = (i > 0 && $urandom_range(0, 3) == 0) ? root_k[0]
                                                           : int'($urandom_range(0, 128)) - 64;
      s1 = root_k[0] + root_k[1] + root_k[2] + root_k[3];
      s2 = root_k[0] * (root_k[1] + root_k[2] + root_k[3])
           + root_k[1] * (root_k[2] + root_k[3]) + root_k[2] * root_k[3];
      s3 = root_k[0] * root_k[1] * (root_k[2] + root_k[3])
           + root_k[2] * root_k[3] * (root_k[0] + root_k[1]);
      s4 = root_k[0] * root_k[1] * root_k[2] * root_k[3];
      m  = int'($urandom_range(1, 4)) * ($urandom_range(0, 1) ? 1 : -1);
      next_coef[CSR_QUARTIC]  = m * 65536;
      next_coef[CSR_CUBIC]    = -m * s1 * 4096;
      next_coef[CSR_SQUARE]   = m * s2 * 256;
      next_coef[CSR_LINEAR]   = -m * s3 * 16;
      next_coef[CSR_CONSTANT] = m * s4;
   endtask

   task automatic choose_coefs(input coef_set_type kind);
      root_phase = (kind == COEFS_ROOTS);
      case (kind)
         COEFS_ALL_MAX:
            for (int i = 0; i < NUM_COEFS; i++) next_coef[i] = COEF_MAX;
         COEFS_ALL_MIN:
            for (int i = 0; i < NUM_COEFS; i++) next_coef[i] = COEF_MIN;
         COEFS_EXTREME_MIX:
            for (int i = 0; i < NUM_COEFS; i++)
               case ($urandom_range(0, 2))
                  0: next_coef[i] = COEF_MAX;
                  1: next_coef[i] = COEF_MIN;
                  default: next_coef[i] = 0;
               endcase
         COEFS_ROOTS:
            make_root_coefs();
         COEFS_WIDE:
            for (int i = 0; i < NUM_COEFS; i++) next_coef[i] = $urandom;
         default:
            for (int i = 0; i < NUM_COEFS; i++) begin
               if ($urandom_range(0, 1))
                  next_coef[i] = 0;
               else if ($urandom_range(0, 1))
                  next_coef[i] = $urandom;
               else
                  next_coef[i] = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            end
      endcase
   endtask

   function automatic logic signed [POINT_WIDTH-1:0] pick_point();
      logic signed [POINT_WIDTH-1:0] pt;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: pt = POINT_WIDTH'($urandom);
         4, 5, 6:    pt = POINT_WIDTH'(int'($urandom_range(0, 3072)) - 1536);
         7: begin
            if (root_phase)
               pt = POINT_WIDTH'(root_k[$urandom_range(0, 3)] * 16);
            else
               pt = POINT_WIDTH'(int'($urandom_range(0, 1024)) - 512);
         end
         8: begin
            case ($urandom_range(0, 4))
               0: pt = POINT_MIN;
               1: pt = POINT_MAX;
               2: pt = 0;
               3: pt = -1;
               default: pt = 1;
            endcase
         end
         default: pt = POINT_WIDTH'(int'($urandom_range(0, 32)) - 16);
      endcase
      return pt;
   endfunction

   // Response stall pattern: a mode is held for a while, then redrawn.
   always @(negedge clock) begin
      rsp_tick <= rsp_tick + 1;
      if (rsp_mode_left == 0) begin
         rsp_mode      <= rsp_mode_type'($urandom_range(0, 3));
         rsp_mode_left <= $urandom_range(40, 160);
      end else begin
         rsp_mode_left <= rsp_mode_left - 1;
      end
      case (rsp_mode)
         RSP_ALWAYS:   rsp_ready <= 1'b1;
         RSP_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
         RSP_SELDOM:   rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= (rsp_tick[2:0] > 3'd4);
      endcase
   end

   always @(posedge clock) begin
      root_count_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_counts.size() == 0) begin
            report_mismatch("response with no request pending", rsp_root_bound, -1);
         end else begin
            want = pending_counts.pop_front();
            if (rsp_root_bound !== want.bound)
               report_mismatch("root_bound", rsp_root_bound, want.bound);
            if (rsp_left_changes !== want.left_cnt)
               report_mismatch("left_changes", rsp_left_changes, want.left_cnt);
            if (rsp_right_changes !== want.right_cnt)
               report_mismatch("right_changes", rsp_right_changes, want.right_cnt);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      stim_row_type       row;
      root_count_type     typed;
      logic signed [POINT_WIDTH-1:0] lp, rp;
      int                 burst_left;
      int                 gap;
      coef_set_type       kind;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_left_point  = '0;
      req_right_point = '0;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      mismatches      = 0;
      rsp_mode        = RSP_ALWAYS;
      rsp_mode_left   = 0;
      rsp_tick        = 0;
      root_phase      = 1'b0;
      for (int i = 0; i < NUM_COEFS; i++) coef_model[i] = '0;
      for (int i = 0; i < 4; i++) root_k[i] = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         case (row.kind)
            ROW_CSR: begin
               if (req_valid)
                  wait_for_responses();
               write_coef(row.index, row.data);
            end
            ROW_PAIR_KNOWN: begin
               if (csr_valid)
                  csr_valid <= 1'b0;
               typed.bound     = row.want_bound;
               typed.left_cnt  = row.want_left;
               typed.right_cnt = row.want_right;
               send_pair(row.left_pt, row.right_pt, typed);
            end
            default: begin
               if (csr_valid)
                  csr_valid <= 1'b0;
               send_pair(row.left_pt, row.right_pt, predict_counts(row.left_pt, row.right_pt));
            end
         endcase
      end

      // random phases, each with a fresh coefficient set
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_responses();
         if (phase == 0)
            kind = COEFS_ALL_MAX;
         else if (phase == 1)
            kind = COEFS_ALL_MIN;
         else if (phase == 2)
            kind = COEFS_EXTREME_MIX;
         else
            case (phase % 4)
               0:       kind = COEFS_WIDE;
               2:       kind = COEFS_SPARSE;
               default: kind = COEFS_ROOTS;
            endcase
         choose_coefs(kind);
         for (int i = 0; i < NUM_COEFS; i++)
            write_coef(CSR_INDEX_W'(i), next_coef[i]);
         // out-of-range index must leave the coefficients alone
         write_coef(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)), $urandom);
         csr_valid  <= 1'b0;
         burst_left = 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == PRESSURE_PHASE && n == ITEMS_PER_PHASE / 2)
               wait_for_responses();
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                        : $urandom_range(1, 24);
               gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               pause_requests(gap);
            end
            burst_left--;
            lp = pick_point();
            rp = pick_point();
            send_pair(lp, rp, predict_counts(lp, rp));
         end
      end

      wait_for_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
